[rtl/sacd_pkg.sv]
// Shared constants, types and codes of the cache tag directory.
package sacd_pkg;

  // Geometry of the directory.
  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_WORDS = 16;

  // Field widths of a 32-bit byte address.
  localparam int ADDR_W     = 32;
  localparam int BYTE_W     = 2;
  localparam int WORD_W     = $clog2(LINE_WORDS);
  localparam int LINE_OFS_W = BYTE_W + WORD_W;
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int TAG_W      = ADDR_W - LINE_OFS_W - SET_W;
  localparam int LINE_W     = ADDR_W - LINE_OFS_W;
  localparam int CNT_W      = 32;

  // Classification of one access.
  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_COLD     = 2'd1,
    OUT_CONFLICT = 2'd2
  } outcome_t;

  // Access types.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  // Directory state of one way.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic             refbit;
  } way_entry_t;

  // One memory row: all ways of a set and the set's clock hand.
  typedef struct packed {
    way_entry_t [WAYS-1:0] ways;
    logic [WAY_W-1:0]      hand;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  // Result of the update logic, handed to the top level.
  typedef struct packed {
    outcome_t          outcome;
    logic [WAY_W-1:0]  way;
    logic              fill;
    logic              wb;
    logic [LINE_W-1:0] victim;
  } result_t;

endpackage

[rtl/sacd_in_if.sv]
// Handshake channel that carries one access transaction into the directory.
interface sacd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [sacd_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output command, output address, input ready);
  modport sink (input valid, input command, input address, output ready);
endinterface

[rtl/sacd_out_if.sv]
// Handshake channel that carries one lookup result out of the directory.
interface sacd_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   outcome;
  logic [sacd_pkg::WAY_W-1:0]   way;
  logic [sacd_pkg::SET_W-1:0]   set_index;
  logic [sacd_pkg::WORD_W-1:0]  word_offset;
  logic                         fill_needed;
  logic                         writeback_needed;
  logic [sacd_pkg::LINE_W-1:0]  victim_line_address;
  logic [sacd_pkg::CNT_W-1:0]   hit_total;
  logic [sacd_pkg::CNT_W-1:0]   cold_total;
  logic [sacd_pkg::CNT_W-1:0]   conflict_total;

  modport source (output valid, output outcome, output way, output set_index,
                  output word_offset, output fill_needed, output writeback_needed,
                  output victim_line_address, output hit_total, output cold_total,
                  output conflict_total, input ready);
  modport sink (input valid, input outcome, input way, input set_index,
                input word_offset, input fill_needed, input writeback_needed,
                input victim_line_address, input hit_total, input cold_total,
                input conflict_total, output ready);
endinterface

[rtl/sacd_ram.sv]
// Set row memory: one synchronous write port and one registered read port.
module sacd_ram (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [sacd_pkg::SET_W-1:0]   rd_addr,
  output sacd_pkg::set_row_t           rd_data,
  input  logic                         wr_en,
  input  logic [sacd_pkg::SET_W-1:0]   wr_addr,
  input  sacd_pkg::set_row_t           wr_data
);

  sacd_pkg::set_row_t mem [sacd_pkg::SETS];
  sacd_pkg::set_row_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/sacd_update.sv]
// Classifies an access against one set row and builds the row to write back.
module sacd_update (
  input  sacd_pkg::set_row_t           row,
  input  logic                         command,
  input  logic [sacd_pkg::TAG_W-1:0]   tag,
  input  logic [sacd_pkg::SET_W-1:0]   set_idx,
  output sacd_pkg::set_row_t           row_new,
  output sacd_pkg::result_t            result
);

  logic                         found;
  logic [sacd_pkg::WAY_W-1:0]   hit_way;
  sacd_pkg::outcome_t           outcome;
  logic                         clear_found;
  logic [sacd_pkg::WAY_W-1:0]   step;
  logic [sacd_pkg::WAY_W-1:0]   victim_way;
  logic [sacd_pkg::WAY_W-1:0]   idx;
  logic [sacd_pkg::WAY_W-1:0]   sel_way;
  sacd_pkg::way_entry_t         victim_entry;

  // Scan the ways in order: the first invalid way is a cold miss, the
  // first matching valid way is a hit, otherwise it is a conflict miss.
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    outcome = sacd_pkg::OUT_CONFLICT;
    for (int w = 0; w < sacd_pkg::WAYS; w++) begin
      if (!found) begin
        if (!row.ways[w].valid) begin
          outcome = sacd_pkg::OUT_COLD;
          hit_way = sacd_pkg::WAY_W'(w);
          found   = 1'b1;
        end else if (row.ways[w].tag == tag) begin
          outcome = sacd_pkg::OUT_HIT;
          hit_way = sacd_pkg::WAY_W'(w);
          found   = 1'b1;
        end
      end
    end
  end

  // Clock hand: the first way from the hand onwards with a clear reference
  // bit is the victim. When every bit is set, a full turn lands on the hand.
  always_comb begin
    clear_found = 1'b0;
    step        = '0;
    idx         = '0;
    for (int i = 0; i < sacd_pkg::WAYS; i++) begin
      idx = row.hand + sacd_pkg::WAY_W'(i);
      if (!clear_found && !row.ways[idx].refbit) begin
        step        = sacd_pkg::WAY_W'(i);
        clear_found = 1'b1;
      end
    end
    victim_way = row.hand + step;
  end

  assign sel_way      = (outcome == sacd_pkg::OUT_CONFLICT) ? victim_way : hit_way;
  assign victim_entry = row.ways[victim_way];

  // New row contents.
  always_comb begin
    row_new = row;
    unique case (outcome)
      sacd_pkg::OUT_HIT: begin
        row_new.ways[hit_way].refbit = 1'b1;
        if (command == sacd_pkg::CMD_WRITE) begin
          row_new.ways[hit_way].dirty = 1'b1;
        end
      end
      sacd_pkg::OUT_COLD: begin
        row_new.ways[hit_way] = '{tag: tag, valid: 1'b1, dirty: command, refbit: 1'b0};
      end
      default: begin
        // Ways the hand passed over lose their reference bit.
        for (int i = 0; i < sacd_pkg::WAYS; i++) begin
          if (!clear_found || (sacd_pkg::WAY_W'(i) < step)) begin
            row_new.ways[row.hand + sacd_pkg::WAY_W'(i)].refbit = 1'b0;
          end
        end
        row_new.ways[victim_way] = '{tag: tag, valid: 1'b1, dirty: command, refbit: 1'b0};
        row_new.hand = victim_way + sacd_pkg::WAY_W'(1);
      end
    endcase
  end

  // Result fields; the eviction fields stay zero unless a line is evicted.
  always_comb begin
    result.outcome = outcome;
    result.way     = sel_way;
    result.fill    = (outcome != sacd_pkg::OUT_HIT);
    result.wb      = 1'b0;
    result.victim  = '0;
    if (outcome == sacd_pkg::OUT_CONFLICT) begin
      result.wb     = victim_entry.dirty;
      result.victim = {victim_entry.tag, set_idx};
    end
  end

endmodule

[rtl/set_assoc_cache_directory_clock_top.sv]
// Top level of the four-way cache tag directory with clock replacement.
//
//   Channel   Direction  Carries
//   in_ch     sink       command, address of one access
//   out_ch    source     outcome, way, set, word, fill/write-back, victim, totals
//
// For an access, the accept edge reads the set row from the row memory; once the
// result slot is free, the lookup classifies it, writes the row back and loads the
// result register, and only then is a new transaction taken.
// Reset clears the row-written flags and the counters; an unwritten row reads as empty.
// While a result waits, one more transaction is taken and its lookup holds until the
// result is taken; no further input is accepted in the meantime.
module set_assoc_cache_directory_clock_top (
  input  logic         clk,
  input  logic         rst_n,
  sacd_in_if.sink      in_ch,
  sacd_out_if.source   out_ch
);

  sacd_pkg::state_t                 state_r, state_nxt;
  logic                             in_ready;
  logic                             advance;

  logic                             cmd_r;
  logic [sacd_pkg::TAG_W-1:0]       tag_r;
  logic [sacd_pkg::SET_W-1:0]       set_r;
  logic [sacd_pkg::WORD_W-1:0]      word_r;

  logic [sacd_pkg::SETS-1:0]        row_written_r, row_written_nxt;
  sacd_pkg::set_row_t               ram_rd_data;
  sacd_pkg::set_row_t               row_cur;
  sacd_pkg::set_row_t               row_new;
  sacd_pkg::result_t                result;

  logic [sacd_pkg::CNT_W-1:0]       hit_cnt_r, hit_cnt_nxt;
  logic [sacd_pkg::CNT_W-1:0]       cold_cnt_r, cold_cnt_nxt;
  logic [sacd_pkg::CNT_W-1:0]       conf_cnt_r, conf_cnt_nxt;

  logic                             out_valid_r, out_valid_nxt;
  sacd_pkg::result_t                out_res_r;
  logic [sacd_pkg::SET_W-1:0]       out_set_r;
  logic [sacd_pkg::WORD_W-1:0]      out_word_r;

  // Sequencer: idle waits for a transaction, lookup waits for the result slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    advance   = 1'b0;
    unique case (state_r)
      sacd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = sacd_pkg::ST_LOOKUP;
        end
      end
      sacd_pkg::ST_LOOKUP: begin
        if (!out_valid_r || out_ch.ready) begin
          advance   = 1'b1;
          state_nxt = sacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacd_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Capture the address fields of an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      cmd_r  <= in_ch.command;
      word_r <= in_ch.address[sacd_pkg::BYTE_W +: sacd_pkg::WORD_W];
      set_r  <= in_ch.address[sacd_pkg::LINE_OFS_W +: sacd_pkg::SET_W];
      tag_r  <= in_ch.address[sacd_pkg::ADDR_W-1 -: sacd_pkg::TAG_W];
    end
  end

  // Row memory, read at the accept edge and written back when the lookup retires.
  sacd_ram u_ram (
    .clk     (clk),
    .rd_en   (in_ch.valid && in_ready),
    .rd_addr (in_ch.address[sacd_pkg::LINE_OFS_W +: sacd_pkg::SET_W]),
    .rd_data (ram_rd_data),
    .wr_en   (advance),
    .wr_addr (set_r),
    .wr_data (row_new)
  );

  // A row that has never been written reads as its reset contents.
  assign row_cur = row_written_r[set_r] ? ram_rd_data : '0;

  always_comb begin
    row_written_nxt = row_written_r;
    if (advance) begin
      row_written_nxt[set_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else begin
      row_written_r <= row_written_nxt;
    end
  end

  sacd_update u_update (
    .row     (row_cur),
    .command (cmd_r),
    .tag     (tag_r),
    .set_idx (set_r),
    .row_new (row_new),
    .result  (result)
  );

  // Statistics counters, wrapping; they move together with the result register.
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    cold_cnt_nxt = cold_cnt_r;
    conf_cnt_nxt = conf_cnt_r;
    if (advance) begin
      unique case (result.outcome)
        sacd_pkg::OUT_HIT:  hit_cnt_nxt  = hit_cnt_r + sacd_pkg::CNT_W'(1);
        sacd_pkg::OUT_COLD: cold_cnt_nxt = cold_cnt_r + sacd_pkg::CNT_W'(1);
        default:            conf_cnt_nxt = conf_cnt_r + sacd_pkg::CNT_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      cold_cnt_r <= '0;
      conf_cnt_r <= '0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      cold_cnt_r <= cold_cnt_nxt;
      conf_cnt_r <= conf_cnt_nxt;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r  <= result;
      out_set_r  <= set_r;
      out_word_r <= word_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.outcome             = out_res_r.outcome;
  assign out_ch.way                 = out_res_r.way;
  assign out_ch.set_index           = out_set_r;
  assign out_ch.word_offset         = out_word_r;
  assign out_ch.fill_needed         = out_res_r.fill;
  assign out_ch.writeback_needed    = out_res_r.wb;
  assign out_ch.victim_line_address = out_res_r.victim;
  assign out_ch.hit_total           = hit_cnt_r;
  assign out_ch.cold_total          = cold_cnt_r;
  assign out_ch.conflict_total      = conf_cnt_r;

`ifndef SYNTHESIS
  // An accepted transaction always moves on to the lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == sacd_pkg::ST_LOOKUP))
    else $error("accepted transaction did not enter lookup");

  // A retired lookup raises exactly one of the three counters by one.
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (sacd_pkg::CNT_W'(hit_cnt_r + cold_cnt_r + conf_cnt_r) ==
                 sacd_pkg::CNT_W'($past(hit_cnt_r + cold_cnt_r + conf_cnt_r) + 1)))
    else $error("counter totals did not advance by one");

  // The row memory is never written while a read for a new transaction is issued.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !in_ready)
    else $error("row write overlaps a row read");
`endif

endmodule

[sim/tb_set_assoc_cache_directory_clock_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the four-way cache tag directory with clock replacement.
module tb_set_assoc_cache_directory_clock_top;
  import sacd_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_ACCESSES = 1700;
  localparam int QUIET_ACCESSES  = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PRINT_LIMIT     = 40;
  localparam int LINES           = SETS * WAYS;

  // Tags used by the directed part; all map to one set so that it fills and evicts.
  localparam logic [TAG_W-1:0] TAG_A = 20'h00000;
  localparam logic [TAG_W-1:0] TAG_B = 20'hFFFFF;
  localparam logic [TAG_W-1:0] TAG_C = 20'h12345;
  localparam logic [TAG_W-1:0] TAG_D = 20'hABCDE;
  localparam logic [TAG_W-1:0] TAG_E = 20'h55555;
  localparam logic [TAG_W-1:0] TAG_F = 20'hAAAAA;
  localparam logic [TAG_W-1:0] TAG_G = 20'h0F0F0;
  localparam logic [TAG_W-1:0] TAG_H = 20'hF0F0F;
  localparam logic [SET_W-1:0] DIRECTED_SET = 6'd5;

  // Everything the directory reports for one lookup.
  typedef struct packed {
    outcome_t          outcome;
    logic [WAY_W-1:0]  way;
    logic [SET_W-1:0]  set_index;
    logic [WORD_W-1:0] word_offset;
    logic              fill_needed;
    logic              writeback_needed;
    logic [LINE_W-1:0] victim_line_address;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  cold_total;
    logic [CNT_W-1:0]  conflict_total;
  } lookup_result_t;

  // Shadow directory that predicts each lookup and holds the results still to come.
  class directory_scoreboard;
    logic [TAG_W-1:0] line_tag [LINES];
    bit               line_valid [LINES];
    bit               line_dirty [LINES];
    bit               line_ref [LINES];
    logic [WAY_W-1:0] set_hand [SETS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] cold_count;
    logic [CNT_W-1:0] conflict_count;
    lookup_result_t   pending_lookups [$];
    int               mismatches;
    int               writebacks_seen;

    function new();
      for (int i = 0; i < LINES; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_ref[i]   = 1'b0;
      end
      for (int s = 0; s < SETS; s++) set_hand[s] = '0;
      hit_count       = '0;
      cold_count      = '0;
      conflict_count  = '0;
      mismatches      = 0;
      writebacks_seen = 0;
    endfunction

    function int outstanding();
      return pending_lookups.size();
    endfunction

    // Classify an accepted access, update the shadow state and queue its result.
    function void note_access(logic cmd, logic [ADDR_W-1:0] addr);
      lookup_result_t   r;
      logic [SET_W-1:0] set_sel;
      logic [TAG_W-1:0] tag_sel;
      logic [WAY_W-1:0] hand;
      int               base;
      int               e;
      bit               found;

      set_sel = addr[LINE_OFS_W +: SET_W];
      tag_sel = addr[ADDR_W-1 -: TAG_W];
      base    = int'(set_sel) * WAYS;
      found   = 1'b0;
      r       = '0;
      r.outcome             = OUT_CONFLICT;
      r.set_index           = set_sel;
      r.word_offset         = addr[BYTE_W +: WORD_W];

      // Ways are searched from 0 upward; an empty way stops the search first.
      for (int w = 0; w < WAYS; w++) begin
        if (!found) begin
          if (!line_valid[base + w]) begin
            r.outcome = OUT_COLD;
            r.way     = WAY_W'(w);
            found     = 1'b1;
          end else if (line_tag[base + w] == tag_sel) begin
            r.outcome = OUT_HIT;
            r.way     = WAY_W'(w);
            found     = 1'b1;
          end
        end
      end

      if (r.outcome == OUT_HIT) begin
        e = base + int'(r.way);
        line_ref[e] = 1'b1;
        if (cmd == CMD_WRITE) line_dirty[e] = 1'b1;
        hit_count++;
      end else begin
        if (r.outcome == OUT_COLD) begin
          cold_count++;
        end else begin
          // The clock hand clears set reference bits until it meets a clear one.
          hand = set_hand[set_sel];
          for (int n = 0; n <= WAYS; n++) begin
            if (!line_ref[base + int'(hand)]) break;
            line_ref[base + int'(hand)] = 1'b0;
            hand = hand + 1'b1;
          end
          r.way = hand;
          set_hand[set_sel] = hand + 1'b1;
          e = base + int'(hand);
          r.writeback_needed    = line_dirty[e];
          r.victim_line_address = {line_tag[e], set_sel};
          conflict_count++;
        end
        e = base + int'(r.way);
        line_tag[e]   = tag_sel;
        line_valid[e] = 1'b1;
        line_dirty[e] = (cmd == CMD_WRITE);
        line_ref[e]   = 1'b0;
        r.fill_needed = 1'b1;
      end

      r.hit_total      = hit_count;
      r.cold_total     = cold_count;
      r.conflict_total = conflict_count;
      pending_lookups.push_back(r);
    endfunction

    task report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
    endtask

    // Compare one result transaction with the oldest prediction.
    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result", CNT_W'(got.outcome), '0);
      end else begin
        want = pending_lookups.pop_front();
        if (got.writeback_needed) writebacks_seen++;
        if (got.outcome != want.outcome)
          report_mismatch("outcome", CNT_W'(got.outcome), CNT_W'(want.outcome));
        if (got.way != want.way)
          report_mismatch("way", CNT_W'(got.way), CNT_W'(want.way));
        if (got.set_index != want.set_index)
          report_mismatch("set_index", CNT_W'(got.set_index), CNT_W'(want.set_index));
        if (got.word_offset != want.word_offset)
          report_mismatch("word_offset", CNT_W'(got.word_offset), CNT_W'(want.word_offset));
        if (got.fill_needed != want.fill_needed)
          report_mismatch("fill_needed", CNT_W'(got.fill_needed), CNT_W'(want.fill_needed));
        if (got.writeback_needed != want.writeback_needed)
          report_mismatch("writeback_needed", CNT_W'(got.writeback_needed),
                          CNT_W'(want.writeback_needed));
        if (got.victim_line_address != want.victim_line_address)
          report_mismatch("victim_line_address", CNT_W'(got.victim_line_address),
                          CNT_W'(want.victim_line_address));
        if (got.hit_total != want.hit_total)
          report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.cold_total != want.cold_total)
          report_mismatch("cold_total", got.cold_total, want.cold_total);
        if (got.conflict_total != want.conflict_total)
          report_mismatch("conflict_total", got.conflict_total, want.conflict_total);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   cycle_count;

  directory_scoreboard board;
  logic [TAG_W-1:0]    tag_pool [8];

  sacd_in_if  in_ch ();
  sacd_out_if out_ch ();

  set_assoc_cache_directory_clock_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit: ends a hung simulation.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run limit of %0d cycles reached with %0d results outstanding.", CYCLE_LIMIT,
             board.outstanding());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] make_address(logic [TAG_W-1:0] tag_sel,
                                                     logic [SET_W-1:0] set_sel,
                                                     logic [WORD_W-1:0] word_sel,
                                                     logic [BYTE_W-1:0] byte_sel);
    return {tag_sel, set_sel, word_sel, byte_sel};
  endfunction

  // Mostly a few tags over a few sets, so that lines are reused and evicted.
  function automatic logic [ADDR_W-1:0] random_address();
    int               pick;
    logic [SET_W-1:0] set_sel;
    pick = $urandom_range(0, 99);
    if (pick < 20) return $urandom;
    set_sel = (pick < 65) ? SET_W'($urandom_range(0, 3)) : SET_W'($urandom_range(0, SETS - 1));
    return make_address(tag_pool[$urandom_range(0, 7)], set_sel,
                        WORD_W'($urandom_range(0, LINE_WORDS - 1)), BYTE_W'($urandom_range(0, 3)));
  endfunction

  // Present one access and hold it until the directory takes it.
  task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
    board.note_access(cmd, addr);
  endtask

  // Result side: checks each transaction and stalls in random bursts.
  initial begin
    int stall_left;
    lookup_result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.outcome             = outcome_t'(out_ch.outcome);
        got.way                 = out_ch.way;
        got.set_index           = out_ch.set_index;
        got.word_offset         = out_ch.word_offset;
        got.fill_needed         = out_ch.fill_needed;
        got.writeback_needed    = out_ch.writeback_needed;
        got.victim_line_address = out_ch.victim_line_address;
        got.hit_total           = out_ch.hit_total;
        got.cold_total          = out_ch.cold_total;
        got.conflict_total      = out_ch.conflict_total;
        board.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed accesses to one set, then random traffic.
  initial begin
    board = new();
    quiet = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_READ;
    in_ch.address <= '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_W'($urandom);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cold misses fill the four ways in order, reads and writes alike.
    send_access(CMD_READ,  make_address(TAG_A, DIRECTED_SET, 4'd0, 2'd0));
    send_access(CMD_WRITE, make_address(TAG_B, DIRECTED_SET, 4'd1, 2'd1));
    send_access(CMD_READ,  make_address(TAG_C, DIRECTED_SET, 4'd2, 2'd2));
    send_access(CMD_WRITE, make_address(TAG_D, DIRECTED_SET, 4'd3, 2'd3));
    // Read and write hits set reference bits; the write makes its line dirty.
    send_access(CMD_READ,  make_address(TAG_A, DIRECTED_SET, 4'd15, 2'd3));
    send_access(CMD_WRITE, make_address(TAG_C, DIRECTED_SET, 4'd7, 2'd0));
    // Conflict: the hand skips a referenced way and evicts a dirty line.
    send_access(CMD_READ,  make_address(TAG_E, DIRECTED_SET, 4'd4, 2'd1));
    // With every reference bit set the hand turns fully and takes its start way.
    send_access(CMD_READ,  make_address(TAG_A, DIRECTED_SET, 4'd5, 2'd0));
    send_access(CMD_READ,  make_address(TAG_E, DIRECTED_SET, 4'd6, 2'd0));
    send_access(CMD_READ,  make_address(TAG_C, DIRECTED_SET, 4'd8, 2'd0));
    send_access(CMD_WRITE, make_address(TAG_D, DIRECTED_SET, 4'd9, 2'd0));
    send_access(CMD_WRITE, make_address(TAG_F, DIRECTED_SET, 4'd10, 2'd2));
    // Further conflicts, one of them with a clean victim.
    send_access(CMD_READ,  make_address(TAG_A, DIRECTED_SET, 4'd11, 2'd0));
    send_access(CMD_READ,  make_address(TAG_G, DIRECTED_SET, 4'd12, 2'd0));
    send_access(CMD_READ,  make_address(TAG_H, DIRECTED_SET, 4'd13, 2'd0));
    // Address extremes; the byte bits must not change the lookup.
    send_access(CMD_READ,  32'h0000_0000);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ,  32'hFFFF_FFFC);
    send_access(CMD_READ,  32'h0000_0003);

    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i == RANDOM_ACCESSES - QUIET_ACCESSES) quiet = 1'b1;
      if (i == RANDOM_ACCESSES / 2) begin
        // Hold off until the directory has returned every result.
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.outstanding() != 0);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, random_address());
    end

    // Drain the remaining results, then allow a few cycles for stray ones.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d hits, %0d cold misses and %0d conflict misses.",
             board.hit_count, board.cold_count, board.conflict_count);
    $display("%0d evictions wrote back a dirty line; %0d mismatches found.",
             board.writebacks_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
